FILE: hw/rtl/ole_pkg.sv
// Package holding the list engine's constants, operation codes and status codes.
package ole_pkg;
    localparam int unsigned CAPACITY = 128;
    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_GET     = 3'd2,
        OP_LOCATE  = 3'd3,
        OP_REVERSE = 3'd4,
        OP_PURGE   = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_NONE    = 3'd7
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_POS_ERR = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;
endpackage

FILE: hw/rtl/ole_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ole_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: hw/rtl/ordered_list_engine.sv
// Top level of the ordered list engine: a sequencer over one entry RAM.
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | s_valid s_ready s_kind s_position s_value
//  m_      | out       | m_valid m_ready m_read_value m_found_position
//          |           | m_list_length m_status
//
// Get, clear, an unused kind and a rejected operation run no per-entry steps.
// Insert, delete and locate add steps for each entry moved or compared, reverse
// for each pair swapped, and purge for each compare against the kept entries,
// so purge grows with the square of the length.
// The single read port sets the cost of these steps.
// Reset is synchronous and clears only the count and the control state.
// A new word is taken while a result waits in the output register; the next
// result then waits in the sequencer until that register is free.
module ordered_list_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_kind,
    input  logic [7:0]                    s_position,
    input  logic signed [31:0]            s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_read_value,
    output logic [7:0]                    m_found_position,
    output logic [7:0]                    m_list_length,
    output logic [1:0]                    m_status
);
    import ole_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD, S_USE, S_USE2, S_PIN_RD, S_PIN_USE, S_PUT, S_DONE
    } state_t;

    state_t              state_reg;
    op_kind_t            kind_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [CNT_W-1:0]    i_reg;
    logic [CNT_W-1:0]    j_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [DATA_W-1:0]   hold_reg;
    logic [DATA_W-1:0]   res_val_reg;
    logic [7:0]          res_found_reg;
    status_t             res_st_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_val_reg;
    logic [7:0]          out_found_reg;
    logic [7:0]          out_len_reg;
    logic [1:0]          out_st_reg;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [DATA_W-1:0]   rd_data;

    ole_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_read_value = out_val_reg;
    assign m_found_position = out_found_reg;
    assign m_list_length = out_len_reg;
    assign m_status = out_st_reg;

    // Read address and write port are worked out from the current step.
    always_comb begin
        rd_addr = i_reg[ADDR_W-1:0];
        wr_en = 1'b0;
        wr_addr = i_reg[ADDR_W-1:0];
        wr_data = rd_data;
        case (state_reg)
            S_RD: begin
                if (kind_reg == OP_INSERT) begin
                    rd_addr = ADDR_W'(i_reg - CNT_W'(1));
                end
            end
            S_USE: begin
                case (kind_reg)
                    OP_INSERT: wr_en = 1'b1;
                    OP_DELETE: begin
                        wr_en = (i_reg != pos_reg - CNT_W'(1));
                        wr_addr = ADDR_W'(i_reg - CNT_W'(1));
                    end
                    OP_REVERSE: rd_addr = j_reg[ADDR_W-1:0];
                    default: wr_en = 1'b0;
                endcase
            end
            S_USE2: wr_en = 1'b1;
            S_PIN_RD: rd_addr = k_reg[ADDR_W-1:0];
            S_PUT: begin
                wr_en = 1'b1;
                if (kind_reg == OP_INSERT) begin
                    wr_addr = ADDR_W'(pos_reg - CNT_W'(1));
                    wr_data = value_reg;
                end else begin
                    wr_addr = j_reg[ADDR_W-1:0];
                    wr_data = hold_reg;
                end
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_DONE && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
                out_val_reg <= res_val_reg;
                out_found_reg <= res_found_reg;
                out_len_reg <= 8'(count_reg);
                out_st_reg <= res_st_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg <= op_kind_t'(s_kind);
                        pos_reg <= CNT_W'(s_position);
                        value_reg <= s_value;
                        res_val_reg <= '0;
                        res_found_reg <= '0;
                        res_st_reg <= ST_OK;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (kind_reg)
                        OP_INSERT: begin
                            if (pos_reg == '0 || pos_reg > count_reg + CNT_W'(1)) begin
                                res_st_reg <= ST_POS_ERR;
                                state_reg <= S_DONE;
                            end else if (count_reg >= CNT_W'(CAPACITY)) begin
                                res_st_reg <= ST_FULL;
                                state_reg <= S_DONE;
                            end else begin
                                i_reg <= count_reg;
                                state_reg <= (count_reg == pos_reg - CNT_W'(1)) ? S_PUT : S_RD;
                            end
                        end
                        OP_DELETE, OP_GET: begin
                            if (pos_reg == '0 || pos_reg > count_reg) begin
                                res_st_reg <= ST_POS_ERR;
                                state_reg <= S_DONE;
                            end else begin
                                i_reg <= pos_reg - CNT_W'(1);
                                state_reg <= S_RD;
                            end
                        end
                        OP_LOCATE: begin
                            i_reg <= '0;
                            state_reg <= (count_reg != '0) ? S_RD : S_DONE;
                        end
                        OP_REVERSE: begin
                            i_reg <= '0;
                            j_reg <= count_reg - CNT_W'(1);
                            state_reg <= (count_reg > CNT_W'(1)) ? S_RD : S_DONE;
                        end
                        OP_PURGE: begin
                            i_reg <= '0;
                            j_reg <= '0;
                            state_reg <= (count_reg != '0) ? S_RD : S_DONE;
                        end
                        OP_CLEAR: begin
                            count_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_RD: state_reg <= S_USE;
                S_USE: begin
                    case (kind_reg)
                        OP_INSERT: begin
                            i_reg <= i_reg - CNT_W'(1);
                            state_reg <= (i_reg == pos_reg) ? S_PUT : S_RD;
                        end
                        OP_DELETE: begin
                            if (i_reg == pos_reg - CNT_W'(1)) res_val_reg <= rd_data;
                            if (i_reg + CNT_W'(1) >= count_reg) begin
                                count_reg <= count_reg - CNT_W'(1);
                                state_reg <= S_DONE;
                            end else begin
                                i_reg <= i_reg + CNT_W'(1);
                                state_reg <= S_RD;
                            end
                        end
                        OP_GET: begin
                            res_val_reg <= rd_data;
                            state_reg <= S_DONE;
                        end
                        OP_LOCATE: begin
                            if (rd_data == value_reg) begin
                                res_found_reg <= 8'(i_reg + CNT_W'(1));
                                state_reg <= S_DONE;
                            end else if (i_reg + CNT_W'(1) >= count_reg) begin
                                state_reg <= S_DONE;
                            end else begin
                                i_reg <= i_reg + CNT_W'(1);
                                state_reg <= S_RD;
                            end
                        end
                        OP_REVERSE: begin
                            hold_reg <= rd_data;
                            state_reg <= S_USE2;
                        end
                        OP_PURGE: begin
                            hold_reg <= rd_data;
                            k_reg <= '0;
                            state_reg <= (j_reg == '0) ? S_PUT : S_PIN_RD;
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_USE2: state_reg <= S_PUT;
                S_PIN_RD: state_reg <= S_PIN_USE;
                S_PIN_USE: begin
                    if (rd_data == hold_reg) begin
                        if (i_reg + CNT_W'(1) >= count_reg) begin
                            count_reg <= j_reg;
                            state_reg <= S_DONE;
                        end else begin
                            i_reg <= i_reg + CNT_W'(1);
                            state_reg <= S_RD;
                        end
                    end else if (k_reg + CNT_W'(1) >= j_reg) begin
                        state_reg <= S_PUT;
                    end else begin
                        k_reg <= k_reg + CNT_W'(1);
                        state_reg <= S_PIN_RD;
                    end
                end
                S_PUT: begin
                    case (kind_reg)
                        OP_INSERT: begin
                            count_reg <= count_reg + CNT_W'(1);
                            state_reg <= S_DONE;
                        end
                        OP_REVERSE: begin
                            i_reg <= i_reg + CNT_W'(1);
                            j_reg <= j_reg - CNT_W'(1);
                            state_reg <= (i_reg + CNT_W'(2) < j_reg) ? S_RD : S_DONE;
                        end
                        OP_PURGE: begin
                            j_reg <= j_reg + CNT_W'(1);
                            if (i_reg + CNT_W'(1) >= count_reg) begin
                                count_reg <= j_reg + CNT_W'(1);
                                state_reg <= S_DONE;
                            end else begin
                                i_reg <= i_reg + CNT_W'(1);
                                state_reg <= S_RD;
                            end
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_DONE: begin
                    if (!out_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("entry RAM written while idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECODE))
        else $error("accepted word did not start an operation");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_val_reg)))
        else $error("pending result lost");
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the ordered list engine, with a list model and random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ole_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1290;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [7:0]         list_length;
        logic [1:0]         status;
    } list_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_kind = OP_NONE;
    logic [7:0]        s_position = '0;
    logic signed [31:0] s_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [31:0] m_read_value;
    logic [7:0]        m_found_position;
    logic [7:0]        m_list_length;
    logic [1:0]        m_status;

    logic [31:0]  model_entries [0:CAPACITY-1];
    int           model_count = 0;
    list_result_t expected_results [$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           quiet = 1'b0;
    logic [31:0]  value_pool [0:7] = '{32'd0, 32'd1, 32'd5, 32'hFFFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF, 32'd42, 32'd7};

    ordered_list_engine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_position(s_position), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_value(m_read_value),
        .m_found_position(m_found_position), .m_list_length(m_list_length),
        .m_status(m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ordered_list_engine test failed");
            $finish;
        end
    end

    function automatic list_result_t apply_operation(logic [2:0] kind, logic [7:0] position,
                                                     logic [31:0] value);
        list_result_t res;
        int           pos;
        int           kept;
        bit           dup;
        logic [31:0]  tmp;
        res = '0;
        pos = int'(position);
        res.status = ST_OK;
        case (op_kind_t'(kind))
            OP_INSERT: begin
                if (pos < 1 || pos > model_count + 1) begin
                    res.status = ST_POS_ERR;
                end else if (model_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int j = model_count; j > pos - 1; j--)
                        model_entries[j] = model_entries[j-1];
                    model_entries[pos-1] = value;
                    model_count++;
                end
            end
            OP_DELETE: begin
                if (pos < 1 || pos > model_count) begin
                    res.status = ST_POS_ERR;
                end else begin
                    res.read_value = model_entries[pos-1];
                    for (int j = pos; j < model_count; j++)
                        model_entries[j-1] = model_entries[j];
                    model_count--;
                end
            end
            OP_GET: begin
                if (pos < 1 || pos > model_count) res.status = ST_POS_ERR;
                else res.read_value = model_entries[pos-1];
            end
            OP_LOCATE: begin
                for (int j = 0; j < model_count; j++) begin
                    if (model_entries[j] == value) begin
                        res.found_position = 8'(j + 1);
                        break;
                    end
                end
            end
            OP_REVERSE: begin
                for (int j = 0; j < model_count / 2; j++) begin
                    tmp = model_entries[j];
                    model_entries[j] = model_entries[model_count-1-j];
                    model_entries[model_count-1-j] = tmp;
                end
            end
            OP_PURGE: begin
                kept = 0;
                for (int r = 0; r < model_count; r++) begin
                    dup = 1'b0;
                    for (int k = 0; k < kept; k++)
                        if (model_entries[k] == model_entries[r]) dup = 1'b1;
                    if (!dup) begin
                        model_entries[kept] = model_entries[r];
                        kept++;
                    end
                end
                model_count = kept;
            end
            OP_CLEAR: model_count = 0;
            default: ;
        endcase
        res.list_length = model_count[7:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word, list_length", 32'(m_list_length), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_read_value !== want.read_value)
                    report_mismatch("read_value", m_read_value, want.read_value);
                if (m_found_position !== want.found_position)
                    report_mismatch("found_position", 32'(m_found_position),
                                    32'(want.found_position));
                if (m_list_length !== want.list_length)
                    report_mismatch("list_length", 32'(m_list_length), 32'(want.list_length));
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 8);
    end

    task automatic send_item(logic [2:0] kind, logic [7:0] position, logic [31:0] value);
        @(negedge aclk);
        s_valid = 1'b1;
        s_kind = kind;
        s_position = position;
        s_value = value;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_operation(kind, position, value));
        if (!quiet && $urandom_range(0, 99) < 8) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(OP_DELETE, 8'd1, 32'd0);
        send_item(OP_GET, 8'd0, 32'd0);
        send_item(OP_INSERT, 8'd0, 32'd9);
        send_item(OP_INSERT, 8'd2, 32'd9);
        send_item(OP_REVERSE, 8'd0, 32'd0);
        send_item(OP_PURGE, 8'd0, 32'd0);
        send_item(OP_INSERT, 8'd1, 32'h8000_0000);
        send_item(OP_REVERSE, 8'd0, 32'd0);
        send_item(OP_INSERT, 8'd2, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 8'd1, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 8'd4, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 8'd2, 32'h8000_0000);
        send_item(OP_INSERT, 8'd255, 32'd1);
        send_item(OP_GET, 8'd5, 32'd0);
        send_item(OP_GET, 8'd6, 32'd0);
        send_item(OP_GET, 8'd255, 32'd0);
        send_item(OP_LOCATE, 8'd0, 32'h7FFF_FFFF);
        send_item(OP_LOCATE, 8'd0, 32'd12345);
        send_item(OP_REVERSE, 8'd0, 32'd0);
        send_item(OP_NONE, 8'hFF, 32'hFFFF_FFFF);
        send_item(OP_PURGE, 8'd0, 32'd0);
        send_item(OP_DELETE, 8'd3, 32'd0);
        send_item(OP_DELETE, 8'd0, 32'd0);
        send_item(OP_CLEAR, 8'd0, 32'd0);
        send_item(OP_GET, 8'd1, 32'd0);
    endtask

    task automatic test_full_list();
        send_item(OP_CLEAR, 8'd0, 32'd0);
        for (int i = 0; i < CAPACITY; i++)
            send_item(OP_INSERT, 8'($urandom_range(1, model_count + 1)),
                      value_pool[$urandom_range(0, 3)]);
        send_item(OP_INSERT, 8'd129, 32'd1);
        send_item(OP_INSERT, 8'd130, 32'd1);
        send_item(OP_INSERT, 8'd1, 32'd1);
        send_item(OP_GET, 8'd128, 32'd0);
        send_item(OP_LOCATE, 8'd0, value_pool[3]);
        send_item(OP_REVERSE, 8'd0, 32'd0);
        send_item(OP_DELETE, 8'd128, 32'd0);
        send_item(OP_INSERT, 8'd128, 32'h7FFF_FFFF);
        send_item(OP_PURGE, 8'd0, 32'd0);
    endtask

    task automatic test_random();
        int          pick;
        logic [2:0]  kind;
        logic [7:0]  position;
        logic [31:0] value;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 200 && i < 450);
            if (i == 700) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 40) kind = OP_INSERT;
            else if (pick < 58) kind = OP_DELETE;
            else if (pick < 72) kind = OP_GET;
            else if (pick < 84) kind = OP_LOCATE;
            else if (pick < 90) kind = OP_REVERSE;
            else if (pick < 93) kind = OP_PURGE;
            else if (pick < 96) kind = OP_CLEAR;
            else if (pick < 98) kind = OP_NONE;
            else kind = 3'($urandom_range(0, 7));
            if (kind == OP_INSERT && model_count > 48 && $urandom_range(0, 1)) kind = OP_DELETE;
            if ($urandom_range(0, 9) == 0) position = 8'($urandom_range(0, 255));
            else if (kind == OP_INSERT) position = 8'($urandom_range(1, model_count + 1));
            else position = 8'($urandom_range(1, model_count > 0 ? model_count : 1));
            if (kind == OP_LOCATE && model_count > 0 && $urandom_range(0, 9) < 6)
                value = model_entries[$urandom_range(0, model_count - 1)];
            else if ($urandom_range(0, 1)) value = value_pool[$urandom_range(0, 7)];
            else value = $urandom;
            send_item(kind, position, value);
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_full_list();
        test_random();
        drain_results();
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ordered_list_engine test passed");
        end else begin
            $display("ordered_list_engine test failed");
        end
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/ole_pkg.sv
hw/rtl/ole_ram.sv
hw/rtl/ordered_list_engine.sv
tb/testbench.sv
